@@ rtl/ptc_pkg.sv @@
package ptc_pkg;

  // register indexes of the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_CALIB = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_LOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_HIGH = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_LAST = 2'd3;

  // fraction bits kept of the q24.8 pressure
  localparam int unsigned PRESS_FRAC_BITS = 8;
  localparam int unsigned PressShift = 8 - PRESS_FRAC_BITS;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } ptc_in_t;

  typedef struct packed {
    logic signed [15:0] temp_centi;
    logic        [31:0] press_q8;
    logic signed [31:0] fine_temperature;
    logic               press_invalid;
  } ptc_out_t;

  // side data that rides along the pressure pipeline
  typedef struct packed {
    logic signed [15:0] temp_centi;
    logic signed [31:0] fine;
    logic               invalid;
  } ptc_carry_t;

  // low 32-bit word of a 64-bit pattern times a signed 17-bit word, sign extended
  function automatic logic [63:0] pp_lo(input logic [31:0] x, input logic signed [16:0] w);
    logic signed [49:0] pr;
    pr = $signed({1'b0, x}) * w;
    return 64'(pr);
  endfunction

  // high word times the same weight, only what lands below bit 64 counts
  function automatic logic [31:0] pp_hi(input logic [31:0] x, input logic signed [16:0] w);
    logic [31:0] ws;
    logic [31:0] pr;
    ws = 32'(w);
    pr = x * ws;
    return pr;
  endfunction

endpackage

@@ rtl/pressure_temperature_compensation_core.sv @@
// Compensation of raw barometer samples into temperature and pressure.
// Input channel (in_valid_i / in_ready_o / in_data_i): one beat carries one
// raw temperature and one raw pressure sample. Output channel (out_valid_o /
// out_ready_i / out_data_o): one beat per input beat, in order, with the
// temperature in 0.01 degC, pressure in pascal q24.8, the fine temperature
// and a flag for a zero pressure denominator.
// Calibration words come in over the write channel cfg_valid_i / cfg_ready_o
// with cfg_index_i and cfg_data_i; it is always ready and should be used only
// while no beat is in flight.
// One beat can enter every cycle while the pipeline is not held. The depth
// from input beat to output valid is set by the 64-stage restoring divider,
// one quotient bit per stage, plus the split 64-bit products around it.
// Reset clears the calibration registers and all stage valid bits.
// When the output beat is not taken, the whole pipeline holds and
// in_ready_o drops in the same cycle; nothing is lost or repeated.
module pressure_temperature_compensation_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ptc_pkg::ptc_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ptc_pkg::ptc_out_t                  out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ptc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [63:0]                        cfg_data_i
);

  localparam int unsigned DivBits = 64;
  localparam int unsigned LastStg = 84;

  // calibration registers
  logic [47:0] temp_calib_q;
  logic [63:0] press_low_q;
  logic [63:0] press_high_q;
  logic [15:0] press_last_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_low_q  <= '0;
      press_high_q <= '0;
      press_last_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ptc_pkg::CFG_TEMP_CALIB: temp_calib_q <= cfg_data_i[47:0];
        ptc_pkg::CFG_PRESS_LOW:  press_low_q  <= cfg_data_i;
        ptc_pkg::CFG_PRESS_HIGH: press_high_q <= cfg_data_i;
        ptc_pkg::CFG_PRESS_LAST: press_last_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic        [15:0] t1;
  logic signed [15:0] t2, t3;
  logic signed [16:0] p1w, p3w, p6w, p8w, p9w;
  logic signed [15:0] p2, p4, p5, p7;

  assign t1  = temp_calib_q[15:0];
  assign t2  = $signed(temp_calib_q[31:16]);
  assign t3  = $signed(temp_calib_q[47:32]);
  assign p1w = $signed({1'b0, press_low_q[15:0]});
  assign p2  = $signed(press_low_q[31:16]);
  assign p3w = $signed({press_low_q[47], press_low_q[47:32]});
  assign p4  = $signed(press_low_q[63:48]);
  assign p5  = $signed(press_high_q[15:0]);
  assign p6w = $signed({press_high_q[31], press_high_q[31:16]});
  assign p7  = $signed(press_high_q[47:32]);
  assign p8w = $signed({press_high_q[63], press_high_q[63:48]});
  assign p9w = $signed({press_last_q[15], press_last_q});

  // global advance: the pipeline moves unless a finished beat waits
  logic adv;
  logic vld_q [1:LastStg];

  assign adv         = !vld_q[LastStg] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[LastStg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= LastStg; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[1] <= in_valid_i;
      for (int k = 2; k <= LastStg; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // ---------------- temperature ----------------
  logic signed [17:0] d1_d, d1_q;
  logic signed [16:0] d2_d, d2_q;
  logic        [20:0] pn_d;
  logic        [20:0] pn_q [1:9];
  logic signed [33:0] m1_d, m1_q, m2_d, m2_q;
  logic signed [22:0] ta_d, ta_q;
  logic signed [37:0] m3_d, m3_q;
  logic signed [31:0] fine_d, fine_q;
  logic signed [32:0] x_d, x_q;
  logic signed [35:0] t5x;
  logic signed [27:0] tsh;
  logic signed [15:0] tc_d;

  assign d1_d = $signed({1'b0, in_data_i.raw_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d2_d = $signed({1'b0, in_data_i.raw_temp[19:4]}) - $signed({1'b0, t1});
  assign pn_d = 21'h100000 - {1'b0, in_data_i.raw_press};
  assign m1_d = d1_q * t2;
  assign m2_d = d2_q * d2_q;
  assign ta_d = $signed(m1_q[33:11]);
  assign m3_d = $signed(m2_q[33:12]) * t3;
  assign fine_d = 32'($signed(ta_q)) + 32'($signed(m3_q[37:14]));
  assign x_d  = 33'(fine_q) - 33'sd128000;
  assign t5x  = (36'(fine_q) <<< 2) + 36'(fine_q) + 36'sd128;
  assign tsh  = $signed(t5x[35:8]);

  always_comb begin
    if (tsh > 28'sd32767) begin
      tc_d = 16'sh7fff;
    end else if (tsh < -28'sd32768) begin
      tc_d = 16'sh8000;
    end else begin
      tc_d = tsh[15:0];
    end
  end

  // ---------------- pressure front end ----------------
  ptc_pkg::ptc_carry_t cy_q [5:LastStg-1];

  logic signed [65:0] xsq;
  logic signed [48:0] xp5_d, xp5_q, xp2_d, xp2_q;
  logic [63:0] xx_q;
  logic [63:0] b6lo_q, a3lo_q, bpart_q, apart_q;
  logic [31:0] b6hi_q, a3hi_q;
  logic [63:0] bxx_q, axx_q, bpart8_q, apart8_q;
  logic [63:0] b9_d, b9_q, a9_d, a9_q;
  logic [63:0] c10_d, c10_q, n10_d, n10_q;
  logic [63:0] clo_q, nlo_q;
  logic [31:0] chi_q, nhi_q;
  logic [63:0] cp_d, cp_q, np_d, np_q;
  logic [63:0] den, ua_d, ub_d;
  logic        inv_d, neg_d;

  assign xsq   = x_q * x_q;
  assign xp5_d = x_q * p5;
  assign xp2_d = x_q * p2;
  assign b9_d  = bxx_q + bpart8_q;
  assign a9_d  = {{8{axx_q[63]}}, axx_q[63:8]} + apart8_q;
  assign c10_d = a9_q + 64'h0000_8000_0000_0000;
  assign n10_d = {12'd0, pn_q[9], 31'd0} - b9_q;
  assign cp_d  = clo_q + {chi_q, 32'd0};
  assign np_d  = nlo_q + {nhi_q, 32'd0};
  assign den   = {{33{cp_q[63]}}, cp_q[63:33]};
  assign inv_d = (den == 64'd0);
  assign neg_d = np_q[63] ^ den[63];
  assign ua_d  = np_q[63] ? (64'd0 - np_q) : np_q;
  assign ub_d  = den[63] ? (64'd0 - den) : den;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_q    <= d1_d;
      d2_q    <= d2_d;
      pn_q[1] <= pn_d;
      for (int k = 2; k <= 9; k++) pn_q[k] <= pn_q[k-1];
      m1_q    <= m1_d;
      m2_q    <= m2_d;
      ta_q    <= ta_d;
      m3_q    <= m3_d;
      fine_q  <= fine_d;
      x_q     <= x_d;
      cy_q[5] <= '{temp_centi: tc_d, fine: fine_q, invalid: 1'b0};
      for (int k = 6; k <= 12; k++) cy_q[k] <= cy_q[k-1];
      cy_q[13] <= '{temp_centi: cy_q[12].temp_centi, fine: cy_q[12].fine, invalid: inv_d};
      for (int k = 14; k <= LastStg - 1; k++) cy_q[k] <= cy_q[k-1];
      xx_q    <= xsq[63:0];
      xp5_q   <= xp5_d;
      xp2_q   <= xp2_d;
      b6lo_q  <= ptc_pkg::pp_lo(xx_q[31:0], p6w);
      b6hi_q  <= ptc_pkg::pp_hi(xx_q[63:32], p6w);
      a3lo_q  <= ptc_pkg::pp_lo(xx_q[31:0], p3w);
      a3hi_q  <= ptc_pkg::pp_hi(xx_q[63:32], p3w);
      bpart_q <= (64'(xp5_q) << 17) + (64'(p4) << 35);
      apart_q <= 64'(xp2_q) << 12;
      bxx_q   <= b6lo_q + {b6hi_q, 32'd0};
      axx_q   <= a3lo_q + {a3hi_q, 32'd0};
      bpart8_q <= bpart_q;
      apart8_q <= apart_q;
      b9_q    <= b9_d;
      a9_q    <= a9_d;
      c10_q   <= c10_d;
      n10_q   <= n10_d;
      clo_q   <= ptc_pkg::pp_lo(c10_q[31:0], p1w);
      chi_q   <= ptc_pkg::pp_hi(c10_q[63:32], p1w);
      nlo_q   <= ptc_pkg::pp_lo(n10_q[31:0], 17'sd3125);
      nhi_q   <= ptc_pkg::pp_hi(n10_q[63:32], 17'sd3125);
      cp_q    <= cp_d;
      np_q    <= np_d;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  logic [63:0] dv_rem_q [0:DivBits-1];
  logic [63:0] dv_dq_q  [0:DivBits-1];
  logic [63:0] dv_ub_q  [0:DivBits-1];
  logic        dv_neg_q [0:DivBits-1];

  for (genvar j = 0; j < DivBits; j++) begin : g_div
    logic [63:0] rem_in, dq_in, ub_in, rem_d;
    logic        neg_in, qbit;
    logic [64:0] trial;

    if (j == 0) begin : g_first
      assign rem_in = 64'd0;
      assign dq_in  = ua_d;
      assign ub_in  = ub_d;
      assign neg_in = neg_d;
    end else begin : g_next
      assign rem_in = dv_rem_q[j-1];
      assign dq_in  = dv_dq_q[j-1];
      assign ub_in  = dv_ub_q[j-1];
      assign neg_in = dv_neg_q[j-1];
    end

    assign trial = {rem_in, dq_in[63]};
    assign qbit  = (trial >= {1'b0, ub_in});
    assign rem_d = qbit ? 64'(trial - {1'b0, ub_in}) : trial[63:0];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[j] <= rem_d;
        dv_dq_q[j]  <= {dq_in[62:0], qbit};
        dv_ub_q[j]  <= ub_in;
        dv_neg_q[j] <= neg_in;
      end
    end
  end

  // ---------------- pressure back end ----------------
  logic [63:0] q_d, q78_q, q79_q, q80_q, q81_q, q82_q;
  logic [63:0] sq;
  logic [63:0] sslo_q, pblo_q, ss_d, ss_q, pb_d, pb_q;
  logic [31:0] sscr_q, pbhi_q, s9hi_q;
  logic [63:0] s9lo_q, b4_q, b4b_q, as_d, as_q;
  logic [63:0] sum_d, sum_q, pf_d, pf_q, pr;
  ptc_pkg::ptc_out_t out_d, out_q;

  assign q_d   = dv_neg_q[DivBits-1] ? (64'd0 - dv_dq_q[DivBits-1]) : dv_dq_q[DivBits-1];
  assign sq    = {{13{q78_q[63]}}, q78_q[63:13]};
  assign ss_d  = sslo_q + {sscr_q[30:0], 1'b0, 32'd0};
  assign pb_d  = pblo_q + {pbhi_q, 32'd0};
  assign as_d  = s9lo_q + {s9hi_q, 32'd0};
  assign sum_d = q82_q + {{25{as_q[63]}}, as_q[63:25]} + b4b_q;
  assign pf_d  = {{8{sum_q[63]}}, sum_q[63:8]} + (64'(p7) << 4);
  assign pr    = pf_q >> ptc_pkg::PressShift;

  always_comb begin
    out_d.temp_centi       = cy_q[LastStg-1].temp_centi;
    out_d.fine_temperature = cy_q[LastStg-1].fine;
    out_d.press_invalid    = cy_q[LastStg-1].invalid;
    if (cy_q[LastStg-1].invalid || pf_q[63]) begin
      out_d.press_q8 = 32'd0;
    end else if (pr[63:32] != 32'd0) begin
      out_d.press_q8 = 32'hffff_ffff;
    end else begin
      out_d.press_q8 = pr[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q78_q  <= q_d;
      sslo_q <= sq[31:0] * sq[31:0];
      sscr_q <= sq[31:0] * sq[63:32];
      pblo_q <= ptc_pkg::pp_lo(q78_q[31:0], p8w);
      pbhi_q <= ptc_pkg::pp_hi(q78_q[63:32], p8w);
      q79_q  <= q78_q;
      ss_q   <= ss_d;
      pb_q   <= pb_d;
      q80_q  <= q79_q;
      s9lo_q <= ptc_pkg::pp_lo(ss_q[31:0], p9w);
      s9hi_q <= ptc_pkg::pp_hi(ss_q[63:32], p9w);
      b4_q   <= {{19{pb_q[63]}}, pb_q[63:19]};
      q81_q  <= q80_q;
      as_q   <= as_d;
      b4b_q  <= b4_q;
      q82_q  <= q81_q;
      sum_q  <= sum_d;
      pf_q   <= pf_d;
      out_q  <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule
